// File: src/segc_pkg.sv
// Shared types, widths, status codes and the control program of the contact search.
`default_nettype none

package segc_pkg;

   // field widths
   localparam int COORD_W = 24;
   localparam int RAD_W   = 23;
   localparam int TOL_W   = 8;
   localparam int STAT_W  = 2;

   // coordinate difference, its magnitude and the per-step quotient
   localparam int DIFF_W = COORD_W + 1;
   localparam int MAG_W  = COORD_W;
   localparam int QW     = DIFF_W;

   // squared distance widths
   localparam int SQ_W = 2 * COORD_W;
   localparam int D2_W = SQ_W + 1;

   // divider step counter
   localparam int DCNT_W = 2;

   localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_HIT    = 2'd0;
   localparam logic [STAT_W-1:0] ST_INSIDE = 2'd1;
   localparam logic [STAT_W-1:0] ST_NONE   = 2'd2;

   // program step addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] STEP_PREP  = 4'd1;
   localparam logic [PC_W-1:0] STEP_RSQ   = 4'd2;
   localparam logic [PC_W-1:0] STEP_CAPH  = 4'd3;
   localparam logic [PC_W-1:0] STEP_CAPR  = 4'd4;
   localparam logic [PC_W-1:0] STEP_DIV   = 4'd5;
   localparam logic [PC_W-1:0] STEP_FIX   = 4'd6;
   localparam logic [PC_W-1:0] STEP_WALK  = 4'd7;
   localparam logic [PC_W-1:0] STEP_DRAIN = 4'd8;
   localparam logic [PC_W-1:0] STEP_OUT   = 4'd9;

   // operand select for the squarer inputs
   typedef enum logic [1:0] {
      E_WALK = 2'd0,
      E_TOL  = 2'd1,
      E_RAD  = 2'd2
   } esel_type;

   // jump conditions; a step waits until its condition holds
   typedef enum logic [2:0] {
      JC_ALWAYS    = 3'd0,
      JC_ACCEPT    = 3'd1,
      JC_DIV_LAST  = 3'd2,
      JC_WALK_LAST = 3'd3,
      JC_DRAINED   = 3'd4,
      JC_SLOT_FREE = 3'd5
   } jcond_type;

   typedef struct packed {
      logic            req_ready;
      logic            prep;
      logic            div_en;
      logic            cap_bounds;
      logic            cap_radius;
      logic            walk_init;
      logic            issue;
      logic            out_load;
      esel_type        e_sel;
      jcond_type       jump_cond;
      logic [PC_W-1:0] jump_addr;
   } ctrl_type;

   typedef struct packed {
      logic walk_last;
      logic busy;
      logic hit;
   } dp_stat_type;

   typedef struct packed {
      logic        accept;
      logic        div_last;
      logic        slot_free;
      dp_stat_type dp;
   } flags_type;

   // control program, one word per step
   function automatic ctrl_type ucode(input logic [PC_W-1:0] addr);
      ctrl_type w;
      w = '{req_ready: 1'b0, prep: 1'b0, div_en: 1'b0, cap_bounds: 1'b0,
            cap_radius: 1'b0, walk_init: 1'b0, issue: 1'b0, out_load: 1'b0,
            e_sel: E_WALK, jump_cond: JC_ALWAYS, jump_addr: STEP_IDLE};
      unique case (addr)
         STEP_IDLE: begin
            w.req_ready = 1'b1;
            w.jump_cond = JC_ACCEPT;
            w.jump_addr = STEP_PREP;
         end
         STEP_PREP: begin
            w.prep      = 1'b1;
            w.e_sel     = E_TOL;
            w.jump_addr = STEP_RSQ;
         end
         STEP_RSQ: begin
            w.e_sel     = E_RAD;
            w.div_en    = 1'b1;
            w.jump_addr = STEP_CAPH;
         end
         STEP_CAPH: begin
            w.cap_bounds = 1'b1;
            w.div_en     = 1'b1;
            w.jump_addr  = STEP_CAPR;
         end
         STEP_CAPR: begin
            w.cap_radius = 1'b1;
            w.div_en     = 1'b1;
            w.jump_addr  = STEP_DIV;
         end
         STEP_DIV: begin
            w.div_en    = 1'b1;
            w.jump_cond = JC_DIV_LAST;
            w.jump_addr = STEP_FIX;
         end
         STEP_FIX: begin
            w.walk_init = 1'b1;
            w.jump_addr = STEP_WALK;
         end
         STEP_WALK: begin
            w.issue     = 1'b1;
            w.jump_cond = JC_WALK_LAST;
            w.jump_addr = STEP_DRAIN;
         end
         STEP_DRAIN: begin
            w.jump_cond = JC_DRAINED;
            w.jump_addr = STEP_OUT;
         end
         STEP_OUT: begin
            w.out_load  = 1'b1;
            w.jump_cond = JC_SLOT_FREE;
            w.jump_addr = STEP_IDLE;
         end
         default: begin
            w.jump_addr = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: src/segc_seq.sv
// Step counter and program ROM that sequence the contact search.
`default_nettype none

module segc_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  segc_pkg::flags_type  flags,
   output segc_pkg::ctrl_type   ctrl
);
   import segc_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            go;

   // fetch the control word of the current step
   always_comb begin
      ctrl = ucode(pc_ff);
   end

   // evaluate the jump condition
   always_comb begin
      unique case (ctrl.jump_cond)
         JC_ALWAYS:    go = 1'b1;
         JC_ACCEPT:    go = flags.accept;
         JC_DIV_LAST:  go = flags.div_last;
         JC_WALK_LAST: go = flags.dp.walk_last;
         JC_DRAINED:   go = !flags.dp.busy;
         JC_SLOT_FREE: go = flags.slot_free;
         default:      go = 1'b0;
      endcase
   end

   // jump on condition, hold otherwise; a hit ends the walk at once
   always_comb begin
      pc_in = pc_ff;
      if (flags.dp.hit) begin
         pc_in = STEP_OUT;
      end else if (go) begin
         pc_in = ctrl.jump_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: src/segc_div.sv
// Floor division of one segment delta by the sample count through a reciprocal multiply.
`default_nettype none

module segc_div #(
   parameter int SAMPLE_STEPS = 100
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic                                     div_step,
   input  logic signed [segc_pkg::DIFF_W-1:0]       diff,
   output logic signed [segc_pkg::QW-1:0]           q0,
   output logic        [$clog2(SAMPLE_STEPS)-1:0]   r0,
   output logic                                     last
);
   import segc_pkg::*;

   localparam int RW  = $clog2(SAMPLE_STEPS);
   localparam int SH  = MAG_W + RW;
   localparam int M_W = MAG_W + 1;
   localparam int P_W = MAG_W + M_W;
   localparam int NQ_W = MAG_W + RW + 1;
   localparam logic [RW:0] N_W = (RW+1)'(SAMPLE_STEPS);
   // ceil(2^SH / N) gives an exact quotient for every magnitude below 2^MAG_W
   localparam longint RECIP_L =
      ((longint'(1) << SH) + longint'(SAMPLE_STEPS) - 1) / longint'(SAMPLE_STEPS);
   localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

   // divider steps
   localparam logic [DCNT_W-1:0] CNT_MUL  = DCNT_W'(0);
   localparam logic [DCNT_W-1:0] CNT_QUO  = DCNT_W'(1);
   localparam logic [DCNT_W-1:0] CNT_REM  = DCNT_W'(2);
   localparam logic [DCNT_W-1:0] CNT_DONE = DCNT_W'(3);

   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [P_W-1:0]    prod_ff, prod_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;

   logic [DIFF_W-1:0] abs_w;
   logic [P_W-1:0]    prod_w;
   logic [MAG_W-1:0]  quo_w;
   logic [NQ_W-1:0]   qn_w;
   logic [MAG_W-1:0]  rem_w;
   logic [RW:0]       rneg_w;

   // multiply by the reciprocal, take the quotient, then the remainder
   always_comb begin
      abs_w  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      prod_w = P_W'(mag_ff) * P_W'(RECIP);
      quo_w  = MAG_W'(prod_ff >> SH);
      qn_w   = NQ_W'(quo_ff) * NQ_W'(N_W);
      rem_w  = mag_ff - qn_w[MAG_W-1:0];

      mag_in  = mag_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         mag_in = abs_w[MAG_W-1:0];
         neg_in = diff[DIFF_W-1];
         cnt_in = '0;
      end else if (div_step) begin
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == CNT_MUL) begin
            prod_in = prod_w;
         end
         if (cnt_ff == CNT_QUO) begin
            quo_in = quo_w;
         end
         if (cnt_ff == CNT_REM) begin
            rem_in = rem_w[RW-1:0];
         end
      end
   end

   // turn the magnitude quotient into floor quotient and non-negative remainder
   always_comb begin
      rneg_w = N_W - {1'b0, rem_ff};
      if (neg_ff && (rem_ff != '0)) begin
         q0 = $signed(~{1'b0, quo_ff});
         r0 = rneg_w[RW-1:0];
      end else if (neg_ff) begin
         q0 = $signed(QW'(0) - {1'b0, quo_ff});
         r0 = '0;
      end else begin
         q0 = $signed({1'b0, quo_ff});
         r0 = rem_ff;
      end
      last = cnt_ff == CNT_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mag_ff  <= mag_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
   end

endmodule

`default_nettype wire

// File: src/segc_dp.sv
// Datapath: operand capture, sample walk, squared distance pipeline and result.
`default_nettype none

module segc_dp #(
   parameter int SAMPLE_STEPS = 100
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  segc_pkg::ctrl_type                       ctrl,
   input  logic                                     accept,
   input  logic signed [segc_pkg::COORD_W-1:0]      center_x,
   input  logic signed [segc_pkg::COORD_W-1:0]      center_y,
   input  logic signed [segc_pkg::COORD_W-1:0]      first_x,
   input  logic signed [segc_pkg::COORD_W-1:0]      first_y,
   input  logic signed [segc_pkg::COORD_W-1:0]      second_x,
   input  logic signed [segc_pkg::COORD_W-1:0]      second_y,
   input  logic        [segc_pkg::RAD_W-1:0]        radius,
   input  logic        [segc_pkg::TOL_W-1:0]        tol,
   input  logic signed [segc_pkg::QW-1:0]           q0_x,
   input  logic signed [segc_pkg::QW-1:0]           q0_y,
   input  logic        [$clog2(SAMPLE_STEPS)-1:0]   r0_x,
   input  logic        [$clog2(SAMPLE_STEPS)-1:0]   r0_y,
   output logic signed [segc_pkg::DIFF_W-1:0]       diff_x,
   output logic signed [segc_pkg::DIFF_W-1:0]       diff_y,
   output segc_pkg::dp_stat_type                    stat,
   output logic signed [segc_pkg::COORD_W-1:0]      res_x,
   output logic signed [segc_pkg::COORD_W-1:0]      res_y,
   output logic        [segc_pkg::STAT_W-1:0]       res_status
);
   import segc_pkg::*;

   localparam int RW = $clog2(SAMPLE_STEPS);
   localparam int KW = $clog2(SAMPLE_STEPS);
   localparam logic [RW:0]   N_INIT = (RW+1)'(SAMPLE_STEPS);
   localparam logic [RW+1:0] TWO_N  = (RW+2)'(2 * SAMPLE_STEPS);
   localparam logic [KW-1:0] K_LAST = KW'(SAMPLE_STEPS - 1);

   // lane 0 is x, lane 1 is y
   logic signed [COORD_W-1:0] c_req [2];
   logic signed [COORD_W-1:0] f_req [2];
   logic signed [COORD_W-1:0] s_req [2];
   logic signed [QW-1:0]      q0_req [2];
   logic        [RW-1:0]      r0_req [2];

   // captured operands
   logic signed [COORD_W-1:0] c_ff [2], c_in [2];
   logic signed [COORD_W-1:0] f_ff [2], f_in [2];
   logic signed [COORD_W-1:0] s_ff [2], s_in [2];
   logic        [RAD_W-1:0]   r_ff, r_in;
   logic signed [DIFF_W-1:0]  b_ff [2], b_in [2];
   logic                      has_lo_ff, has_lo_in;

   // sample walk
   logic signed [QW-1:0] q0_ff [2], q0_in [2];
   logic        [RW-1:0] r0_ff [2], r0_in [2];
   logic signed [QW-1:0] q_ff [2], q_in [2];
   logic        [RW:0]   rm_ff [2], rm_in [2];
   logic        [KW-1:0] k_ff, k_in;

   // distance pipeline
   logic signed [DIFF_W-1:0]  e_ff [2], e_in [2];
   logic signed [COORD_W-1:0] p0_ff [2], p0_in [2];
   logic                      v0_ff, v0_in;
   logic        [SQ_W-1:0]    sq_ff [2], sq_in [2];
   logic signed [COORD_W-1:0] p1_ff [2];
   logic                      v1_ff, v1_in;
   logic        [D2_W-1:0]    d2_ff, d2_in;
   logic signed [COORD_W-1:0] p2_ff [2];
   logic                      v2_ff, v2_in;
   logic                      hit3_ff, hit3_in;
   logic                      in3_ff, in3_in;
   logic signed [COORD_W-1:0] p3_ff [2];
   logic                      v3_ff, v3_in;

   // squared bounds
   logic [SQ_W-1:0] hi2_ff, hi2_in;
   logic [SQ_W-1:0] lo2_ff, lo2_in;
   logic [SQ_W-1:0] r2_ff, r2_in;

   // result
   logic signed [COORD_W-1:0] res_x_ff, res_x_in;
   logic signed [COORD_W-1:0] res_y_ff, res_y_in;
   logic        [STAT_W-1:0]  res_st_ff, res_st_in;

   // lane arithmetic
   logic signed [DIFF_W-1:0]   diff_w [2];
   logic signed [DIFF_W-1:0]   base_w [2];
   logic signed [DIFF_W:0]     esum_w [2];
   logic signed [DIFF_W-1:0]   psum_w [2];
   logic        [RW+1:0]       tsum_w [2];
   logic        [RW+1:0]       twrap_w [2];
   logic                       carry_w [2];
   logic signed [2*DIFF_W-1:0] prod_w [2];
   logic        [DIFF_W-1:0]   rad_w;
   logic        [DIFF_W-1:0]   tol_w;
   logic                       hit_now;

   assign c_req[0]  = center_x;
   assign c_req[1]  = center_y;
   assign f_req[0]  = first_x;
   assign f_req[1]  = first_y;
   assign s_req[0]  = second_x;
   assign s_req[1]  = second_y;
   assign q0_req[0] = q0_x;
   assign q0_req[1] = q0_y;
   assign r0_req[0] = r0_x;
   assign r0_req[1] = r0_y;

   assign hit_now = v3_ff && hit3_ff;
   assign rad_w   = {2'b00, r_ff};
   assign tol_w   = {{(DIFF_W-TOL_W){1'b0}}, tol};

   // per-lane sums, carries and squares
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         diff_w[i]  = DIFF_W'(f_ff[i]) - DIFF_W'(s_ff[i]);
         base_w[i]  = DIFF_W'(s_ff[i]) - DIFF_W'(c_ff[i]);
         esum_w[i]  = (DIFF_W+1)'(b_ff[i]) + (DIFF_W+1)'(q_ff[i]);
         psum_w[i]  = DIFF_W'(s_ff[i]) + q_ff[i];
         tsum_w[i]  = {1'b0, rm_ff[i]} + {1'b0, r0_ff[i], 1'b0};
         twrap_w[i] = tsum_w[i] - TWO_N;
         carry_w[i] = tsum_w[i] >= TWO_N;
         prod_w[i]  = e_ff[i] * e_ff[i];
      end
   end

   assign diff_x = diff_w[0];
   assign diff_y = diff_w[1];

   // operand capture and walk state
   always_comb begin
      r_in      = r_ff;
      has_lo_in = has_lo_ff;
      k_in      = k_ff;
      for (int i = 0; i < 2; i++) begin
         c_in[i]  = c_ff[i];
         f_in[i]  = f_ff[i];
         s_in[i]  = s_ff[i];
         b_in[i]  = b_ff[i];
         q0_in[i] = q0_ff[i];
         r0_in[i] = r0_ff[i];
         q_in[i]  = q_ff[i];
         rm_in[i] = rm_ff[i];
         if (accept) begin
            c_in[i] = c_req[i];
            f_in[i] = f_req[i];
            s_in[i] = s_req[i];
         end
         if (ctrl.prep) begin
            b_in[i] = base_w[i];
         end
         if (ctrl.walk_init) begin
            q0_in[i] = q0_req[i];
            r0_in[i] = r0_req[i];
            q_in[i]  = '0;
            rm_in[i] = N_INIT;
         end else if (ctrl.issue) begin
            q_in[i]  = q_ff[i] + q0_ff[i] + $signed({{(QW-1){1'b0}}, carry_w[i]});
            rm_in[i] = carry_w[i] ? twrap_w[i][RW:0] : tsum_w[i][RW:0];
         end
      end
      if (accept) begin
         r_in = radius;
      end
      if (ctrl.prep) begin
         has_lo_in = rad_w >= tol_w;
      end
      if (ctrl.walk_init) begin
         k_in = '0;
      end else if (ctrl.issue) begin
         k_in = k_ff + KW'(1);
      end
   end

   // distance pipeline: issue, square, sum, compare
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         p0_in[i] = psum_w[i][COORD_W-1:0];
         sq_in[i] = prod_w[i][SQ_W-1:0];
      end
      unique case (ctrl.e_sel)
         E_TOL: begin
            e_in[0] = $signed(rad_w + tol_w);
            e_in[1] = $signed(rad_w - tol_w);
         end
         E_RAD: begin
            e_in[0] = $signed(rad_w);
            e_in[1] = $signed(rad_w);
         end
         default: begin
            e_in[0] = esum_w[0][DIFF_W-1:0];
            e_in[1] = esum_w[1][DIFF_W-1:0];
         end
      endcase
      v0_in   = ctrl.issue && !hit_now;
      v1_in   = v0_ff && !hit_now;
      v2_in   = v1_ff && !hit_now;
      v3_in   = v2_ff && !hit_now;
      d2_in   = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      hit3_in = (d2_ff < {1'b0, hi2_ff}) && (!has_lo_ff || (d2_ff > {1'b0, lo2_ff}));
      in3_in  = d2_ff < {1'b0, r2_ff};
      hi2_in  = ctrl.cap_bounds ? sq_ff[0] : hi2_ff;
      lo2_in  = ctrl.cap_bounds ? sq_ff[1] : lo2_ff;
      r2_in   = ctrl.cap_radius ? sq_ff[0] : r2_ff;
   end

   // keep the first hit, else the latest inside sample
   always_comb begin
      res_x_in  = res_x_ff;
      res_y_in  = res_y_ff;
      res_st_in = res_st_ff;
      if (ctrl.prep) begin
         res_x_in  = '0;
         res_y_in  = '0;
         res_st_in = ST_NONE;
      end else if (hit_now) begin
         res_x_in  = p3_ff[0];
         res_y_in  = p3_ff[1];
         res_st_in = ST_HIT;
      end else if (v3_ff && in3_ff) begin
         res_x_in  = p3_ff[0];
         res_y_in  = p3_ff[1];
         res_st_in = ST_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      for (int i = 0; i < 2; i++) begin
         c_ff[i]  <= c_in[i];
         f_ff[i]  <= f_in[i];
         s_ff[i]  <= s_in[i];
         b_ff[i]  <= b_in[i];
         q0_ff[i] <= q0_in[i];
         r0_ff[i] <= r0_in[i];
         q_ff[i]  <= q_in[i];
         rm_ff[i] <= rm_in[i];
         e_ff[i]  <= e_in[i];
         p0_ff[i] <= p0_in[i];
         sq_ff[i] <= sq_in[i];
         p1_ff[i] <= p0_ff[i];
         p2_ff[i] <= p1_ff[i];
         p3_ff[i] <= p2_ff[i];
      end
      r_ff      <= r_in;
      has_lo_ff <= has_lo_in;
      k_ff      <= k_in;
      d2_ff     <= d2_in;
      hit3_ff   <= hit3_in;
      in3_ff    <= in3_in;
      hi2_ff    <= hi2_in;
      lo2_ff    <= lo2_in;
      r2_ff     <= r2_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_st_ff <= res_st_in;
   end

   assign stat.walk_last = k_ff == K_LAST;
   assign stat.busy      = v0_ff || v1_ff || v2_ff;
   assign stat.hit       = hit_now;
   assign res_x          = res_x_ff;
   assign res_y          = res_y_ff;
   assign res_status     = res_st_ff;

endmodule

`default_nettype wire

// File: src/segment_circle_contact_search.sv
// Top level of the segment / circle contact search.
//
//   port group   dir   handshake            word
//   req_*        in    req_valid/req_ready  circle center, radius, segment points
//   rsp_*        out   rsp_valid/rsp_ready  contact point and status
//   csr_*        in    csr_write_enable     hit tolerance, 1/256 pixel
//
// One query at a time: no new request is taken until the result word of the last one is
// loaded; a hit on a sample ends the walk at once and sends that sample out.
// Six setup steps (bound squaring, three-step reciprocal divide) precede a walk of one
// sample per cycle through a four-stage squared-distance pipeline.
// Reset loads a tolerance of 3 and leaves the block idle, ready for a request.
// A waiting result word lets the next request in; a new result waits until it is taken.
`default_nettype none

module segment_circle_contact_search #(
   parameter int SAMPLE_STEPS = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_center_x,
   input  logic signed [23:0] req_center_y,
   input  logic signed [23:0] req_first_x,
   input  logic signed [23:0] req_first_y,
   input  logic signed [23:0] req_second_x,
   input  logic signed [23:0] req_second_y,
   input  logic        [22:0] req_circle_radius,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_contact_x,
   output logic signed [23:0] rsp_contact_y,
   output logic        [1:0]  rsp_status,
   input  logic               csr_write_enable,
   input  logic        [7:0]  csr_write_data
);
   import segc_pkg::*;

   localparam int RW = $clog2(SAMPLE_STEPS);

   logic [TOL_W-1:0] tol_ff, tol_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic        [STAT_W-1:0]  rsp_st_ff, rsp_st_in;

   ctrl_type    ctrl;
   flags_type   flags;
   dp_stat_type dp_stat;

   logic                      accept;
   logic                      slot_free;
   logic signed [DIFF_W-1:0]  diff_x, diff_y;
   logic signed [QW-1:0]      q0_x, q0_y;
   logic        [RW-1:0]      r0_x, r0_y;
   logic                      div_last_x, div_last_y;
   logic signed [COORD_W-1:0] res_x, res_y;
   logic        [STAT_W-1:0]  res_status;

   assign req_ready = ctrl.req_ready;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // gather sequencer conditions; both dividers run in lockstep
   always_comb begin
      flags.accept    = accept;
      flags.div_last  = div_last_x && div_last_y;
      flags.slot_free = slot_free;
      flags.dp        = dp_stat;
   end

   segc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   segc_div #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.prep),
      .div_step (ctrl.div_en),
      .diff     (diff_x),
      .q0       (q0_x),
      .r0       (r0_x),
      .last     (div_last_x)
   );

   segc_div #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.prep),
      .div_step (ctrl.div_en),
      .diff     (diff_y),
      .q0       (q0_y),
      .r0       (r0_y),
      .last     (div_last_y)
   );

   segc_dp #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .accept     (accept),
      .center_x   (req_center_x),
      .center_y   (req_center_y),
      .first_x    (req_first_x),
      .first_y    (req_first_y),
      .second_x   (req_second_x),
      .second_y   (req_second_y),
      .radius     (req_circle_radius),
      .tol        (tol_ff),
      .q0_x       (q0_x),
      .q0_y       (q0_y),
      .r0_x       (r0_x),
      .r0_y       (r0_y),
      .diff_x     (diff_x),
      .diff_y     (diff_y),
      .stat       (dp_stat),
      .res_x      (res_x),
      .res_y      (res_y),
      .res_status (res_status)
   );

   // write the tolerance register
   always_comb begin
      tol_in = csr_write_enable ? csr_write_data : tol_ff;
   end

   // load the output word when the slot frees, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_st_in    = rsp_st_ff;
      if (ctrl.out_load && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = res_x;
         rsp_y_in     = res_y;
         rsp_st_in    = res_status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_contact_x = rsp_x_ff;
   assign rsp_contact_y = rsp_y_ff;
   assign rsp_status    = rsp_st_ff;

   // an accepted request starts the program; no second request is taken
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request port still ready after accept");

   // a hit jumps straight to the output step
   a_hit_to_output: assert property (@(posedge clock) disable iff (reset)
      dp_stat.hit |=> ctrl.out_load)
      else $error("hit did not end the walk");

   // no inside sample means a zero contact point
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_st_ff == ST_NONE)) |-> ((rsp_x_ff == '0) && (rsp_y_ff == '0)))
      else $error("nonzero contact point with no inside sample");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_st_ff == ST_HIT) || (rsp_st_ff == ST_INSIDE) ||
                        (rsp_st_ff == ST_NONE)))
      else $error("undefined status code");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the segment / circle contact search block.
`timescale 1ns / 1ps

module tb;
   import segc_pkg::*;

   localparam int SAMPLE_STEPS = 100;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 480;

   localparam longint COORD_MAX = 64'sd8388607;
   localparam longint COORD_MIN = -64'sd8388608;
   localparam longint RAD_MAX   = 64'sd8388607;

   typedef struct {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic        [RAD_W-1:0]   circle_radius;
   } query_type;

   typedef struct {
      logic signed [COORD_W-1:0] contact_x;
      logic signed [COORD_W-1:0] contact_y;
      logic        [STAT_W-1:0]  status;
   } contact_type;

   logic clock;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic signed [COORD_W-1:0] req_first_x = '0;
   logic signed [COORD_W-1:0] req_first_y = '0;
   logic signed [COORD_W-1:0] req_second_x = '0;
   logic signed [COORD_W-1:0] req_second_y = '0;
   logic        [RAD_W-1:0]   req_circle_radius = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_contact_x;
   logic signed [COORD_W-1:0] rsp_contact_y;
   logic        [STAT_W-1:0]  rsp_status;
   logic                      csr_write_enable = 1'b0;
   logic        [TOL_W-1:0]   csr_write_data = '0;

   // model copy of the tolerance register
   logic [TOL_W-1:0] tolerance = TOL_RESET;

   contact_type contact_q[$];
   int unsigned send_idle_pct   = 0;
   int unsigned recv_stall_pct  = 0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned fail_count      = 0;
   int unsigned cycle_count     = 0;

   segment_circle_contact_search u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .req_circle_radius (req_circle_radius),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_contact_x     (rsp_contact_x),
      .rsp_contact_y     (rsp_contact_y),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor division for a positive divisor
   function automatic longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   // walk the samples from the second point toward the first
   function automatic contact_type predict_contact(query_type q, logic [TOL_W-1:0] tol);
      longint      cx, cy, fx, fy, sx, sy, r, t, px, py, ex, ey, d2, hi2, lo2;
      bit          has_lo;
      contact_type c;
      cx = q.center_x;
      cy = q.center_y;
      fx = q.first_x;
      fy = q.first_y;
      sx = q.second_x;
      sy = q.second_y;
      r  = q.circle_radius;
      t  = tol;
      hi2    = (r + t) * (r + t);
      has_lo = (r - t) >= 0;
      lo2    = has_lo ? (r - t) * (r - t) : 0;
      c.contact_x = '0;
      c.contact_y = '0;
      c.status    = ST_NONE;
      for (int k = 0; k < SAMPLE_STEPS; k++) begin
         px = sx + floor_div(2 * (fx - sx) * k + SAMPLE_STEPS, 2 * SAMPLE_STEPS);
         py = sy + floor_div(2 * (fy - sy) * k + SAMPLE_STEPS, 2 * SAMPLE_STEPS);
         ex = px - cx;
         ey = py - cy;
         d2 = ex * ex + ey * ey;
         if (d2 < hi2 && (!has_lo || d2 > lo2)) begin
            c.contact_x = px[COORD_W-1:0];
            c.contact_y = py[COORD_W-1:0];
            c.status    = ST_HIT;
            break;
         end
         if (d2 < r * r) begin
            c.contact_x = px[COORD_W-1:0];
            c.contact_y = py[COORD_W-1:0];
            c.status    = ST_INSIDE;
         end
      end
      return c;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX[COORD_W-1:0];
      if (v < COORD_MIN) return COORD_MIN[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   function automatic longint rand_offset(longint span);
      return longint'($urandom_range(32'(2 * span))) - span;
   endfunction

   function automatic query_type make_query(longint cx, longint cy, longint fx, longint fy,
                                            longint sx, longint sy, longint r);
      query_type q;
      q.center_x      = clamp_coord(cx);
      q.center_y      = clamp_coord(cy);
      q.first_x       = clamp_coord(fx);
      q.first_y       = clamp_coord(fy);
      q.second_x      = clamp_coord(sx);
      q.second_y      = clamp_coord(sy);
      q.circle_radius = r[RAD_W-1:0];
      return q;
   endfunction

   // mostly segments near the circle, some raw bit noise
   function automatic query_type random_query();
      query_type   q;
      longint      cx, cy, r, span, sx, sy;
      int unsigned shape;
      shape = $urandom_range(99);
      if (shape < 20) begin
         q.center_x      = COORD_W'($urandom);
         q.center_y      = COORD_W'($urandom);
         q.first_x       = COORD_W'($urandom);
         q.first_y       = COORD_W'($urandom);
         q.second_x      = COORD_W'($urandom);
         q.second_y      = COORD_W'($urandom);
         q.circle_radius = RAD_W'($urandom);
         return q;
      end
      q.center_x = COORD_W'($urandom);
      q.center_y = COORD_W'($urandom);
      cx = q.center_x;
      cy = q.center_y;
      if (shape < 70) r = $urandom_range(6000);
      else if (shape < 85) r = $urandom_range(1 << 20);
      else r = $urandom_range(200);
      span = r + $urandom_range(2000) + 1;
      if (shape < 35) begin
         // start on the circle rim so the first sample may hit
         sx = cx + ($urandom_range(1) ? r : -r) + longint'($urandom_range(4)) - 2;
         sy = cy + longint'($urandom_range(4)) - 2;
      end else begin
         sx = cx + rand_offset(span);
         sy = cy + rand_offset(span);
      end
      if ($urandom_range(19) == 0)
         q = make_query(cx, cy, sx, sy, sx, sy, r);
      else
         q = make_query(cx, cy, cx + rand_offset(span), cy + rand_offset(span), sx, sy, r);
      return q;
   endfunction

   // offer one word and record its expected contact once accepted
   task automatic offer_query(input query_type q);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_center_x      <= q.center_x;
      req_center_y      <= q.center_y;
      req_first_x       <= q.first_x;
      req_first_y       <= q.first_y;
      req_second_x      <= q.second_x;
      req_second_y      <= q.second_y;
      req_circle_radius <= q.circle_radius;
      do @(posedge clock); while (!req_ready);
      contact_q.push_back(predict_contact(q, tolerance));
   endtask

   // send a batch, then drop valid and wait for every result word
   task automatic run_queries(input query_type list[$]);
      foreach (list[i]) offer_query(list[i]);
      req_valid <= 1'b0;
      while (contact_q.size() != 0) @(posedge clock);
   endtask

   // write the tolerance only once the block has gone idle
   task automatic write_tolerance(input logic [TOL_W-1:0] value);
      while (contact_q.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance = value;
   endtask

   task automatic test_directed_cases();
      query_type list[$];
      // reset tolerance: zero radius, rim start, last inside, none inside, extremes
      list.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_query(0, 0, 5000, 0, 1000, 0, 1000));
      list.push_back(make_query(0, 0, 50300, 0, 0, 0, 10000));
      list.push_back(make_query(0, 0, 200000, 200000, 100000, 100000, 100));
      list.push_back(make_query(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MAX, COORD_MIN, RAD_MAX));
      list.push_back(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                COORD_MIN, COORD_MIN, RAD_MAX));
      list.push_back(make_query(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 0));
      list.push_back(make_query(100, 100, 150, 80, 150, 80, 500));
      list.push_back(make_query(0, 0, -2, 5, 3, -7, 4));
      list.push_back(make_query(0, 0, 10, 0, 0, 0, 3));
      list.push_back(make_query(-1, -1, -101, -1, 99, -1, 50));
      run_queries(list);
      // zero tolerance: only the inside search applies
      write_tolerance(8'd0);
      list.delete();
      list.push_back(make_query(0, 0, 50300, 0, 0, 0, 10000));
      list.push_back(make_query(100, 100, 150, 80, 150, 80, 500));
      list.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_query(0, 0, 5000, 0, 1000, 0, 1000));
      run_queries(list);
      // widest tolerance
      write_tolerance(8'd255);
      list.delete();
      list.push_back(make_query(0, 0, 5000, 0, 1000, 0, 1000));
      list.push_back(make_query(0, 0, 50300, 0, 0, 0, 10000));
      list.push_back(make_query(0, 0, 1000, 0, 0, 0, 100));
      list.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
      list.push_back(make_query(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                COORD_MAX, COORD_MIN, 255));
      run_queries(list);
   endtask

   task automatic test_random_traffic();
      int unsigned      send_pct [4] = '{0, 53, 0, 8};
      int unsigned      recv_pct [4] = '{0, 0, 53, 8};
      logic [TOL_W-1:0] tol_set  [4];
      query_type        list[$];
      tol_set = '{8'd255, 8'd0, TOL_W'($urandom_range(254, 1)), 8'd3};
      for (int p = 0; p < 4; p++) begin
         write_tolerance(tol_set[p]);
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         list.delete();
         repeat (PHASE_ITEMS) list.push_back(random_query());
         run_queries(list);
      end
   endtask

   // hold the result channel off long enough that the input stalls
   task automatic test_output_backpressure();
      query_type list[$];
      write_tolerance(TOL_W'($urandom_range(255)));
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 800;
      repeat (40) list.push_back(random_query());
      run_queries(list);
   endtask

   // check each accepted result word, then choose the next ready
   always @(posedge clock) begin : rsp_monitor
      contact_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (contact_q.size() == 0) begin
               $display("%0t: unexpected result word x=%0d y=%0d status=%0d",
                        $time, rsp_contact_x, rsp_contact_y, rsp_status);
               fail_count++;
            end else begin
               want = contact_q.pop_front();
               if (rsp_contact_x !== want.contact_x || rsp_contact_y !== want.contact_y ||
                   rsp_status !== want.status) begin
                  $display("%0t: expected x=%0d y=%0d status=%0d, actual x=%0d y=%0d status=%0d",
                           $time, want.contact_x, want.contact_y, want.status,
                           rsp_contact_x, rsp_contact_y, rsp_status);
                  fail_count++;
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // end the run if it hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("segment_circle_contact_search: mismatch");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic();
      test_output_backpressure();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && contact_q.size() == 0)
         $display("segment_circle_contact_search: match");
      else
         $display("segment_circle_contact_search: mismatch");
      $finish;
   end

endmodule

// File: segment_circle_contact_search.f
src/segc_pkg.sv
src/segc_seq.sv
src/segc_div.sv
src/segc_dp.sv
src/segment_circle_contact_search.sv
test/tb.sv
